// ----- rtl/core/scfa_pkg.sv -----
// ----------------------------------------------------------------------------
// scfa_pkg: shared types and constants of the constant-folding ALU
// Opcodes, field widths and the control word that moves down the cell row.
// ----------------------------------------------------------------------------
package scfa_pkg;

	localparam int unsigned DataW  = 64;
	localparam int unsigned FuncW  = 5;
	localparam int unsigned SizeW  = 4;
	localparam int unsigned QbitW  = 6;

	localparam logic [FuncW-1:0] OpAdd = 5'd0;
	localparam logic [FuncW-1:0] OpSub = 5'd1;
	localparam logic [FuncW-1:0] OpMul = 5'd2;
	localparam logic [FuncW-1:0] OpDiv = 5'd3;
	localparam logic [FuncW-1:0] OpMod = 5'd4;
	localparam logic [FuncW-1:0] OpAnd = 5'd5;
	localparam logic [FuncW-1:0] OpOr  = 5'd6;
	localparam logic [FuncW-1:0] OpXor = 5'd7;
	localparam logic [FuncW-1:0] OpShl = 5'd8;
	localparam logic [FuncW-1:0] OpShr = 5'd9;
	localparam logic [FuncW-1:0] OpSar = 5'd10;
	localparam logic [FuncW-1:0] OpRor = 5'd11;
	localparam logic [FuncW-1:0] OpEq  = 5'd12;
	localparam logic [FuncW-1:0] OpNe  = 5'd13;
	localparam logic [FuncW-1:0] OpLt  = 5'd14;
	localparam logic [FuncW-1:0] OpLe  = 5'd15;
	localparam logic [FuncW-1:0] OpGt  = 5'd16;
	localparam logic [FuncW-1:0] OpGe  = 5'd17;
	localparam logic [FuncW-1:0] OpNot = 5'd18;
	localparam logic [FuncW-1:0] OpNeg = 5'd19;
	localparam logic [FuncW-1:0] OpAbs = 5'd20;

	// Item carried by every cell: opcode, masked operands and running step state
	typedef struct packed {
		logic             vld;
		logic [FuncW-1:0] func;
		logic [SizeW-1:0] size;
		logic             ok;
		logic [DataW-1:0] mask;
		logic [DataW-1:0] res;   // early result, or masked lhs for rotate
		logic [DataW-1:0] dvd;   // dividend or multiplier, shifts left
		logic [DataW-1:0] dvs;   // divisor or multiplicand
		logic [DataW-1:0] rem;   // partial remainder or product
	} scfa_item_t;

	function automatic logic [DataW-1:0] size_mask(input logic [SizeW-1:0] sz);
		logic [DataW-1:0] m;
		m = '1;
		if (sz >= 4'd1 && sz <= 4'd7)
			m = (64'd1 << {sz[2:0], 3'b000}) - 64'd1;
		return m;
	endfunction

endpackage

// ----- rtl/core/scfa_front.sv -----
// ----------------------------------------------------------------------------
// scfa_front: operand masking and combinational folding
// Folds the simple ops; mul, div, mod and rotate finish in the cell row.
// ----------------------------------------------------------------------------
module scfa_front import scfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [FuncW-1:0] func,
	input  logic [SizeW-1:0] size_bytes,
	input  logic [DataW-1:0] lhs,
	input  logic [DataW-1:0] rhs,
	output scfa_item_t       item_s1
);

	logic [DataW-1:0] m, a, b, r, ka, kb;
	logic             ok, szok, big;
	logic [QbitW:0]   bits;
	logic [DataW-1:0] s_a;
	logic [DataW-1:0] dvd_in, dvs_in;

	assign m    = size_mask(size_bytes);
	assign a    = lhs & m;
	assign b    = rhs & m;
	assign szok = (size_bytes >= 4'd1) && (size_bytes <= 4'd8);
	assign big  = |b[DataW-1:QbitW];
	assign bits = {size_bytes[3:0], 3'b000};
	assign ka   = ((a & ~(m >> 1) & m) != '0 && m != '1) ? (a | ~m) : a;
	assign kb   = ((b & ~(m >> 1) & m) != '0 && m != '1) ? (b | ~m) : b;
	assign s_a  = a;
	// rotate reduces rhs modulo the width in the division cells
	assign dvd_in = (func == OpRor) ? b : a;
	assign dvs_in = (func == OpRor) ? {57'd0, bits} : b;

	always_comb begin
		r  = '0;
		ok = 1'b0;
		if (func == OpNot) begin
			r = ~lhs; ok = 1'b1;
		end else if (func == OpNeg) begin
			r = -lhs; ok = 1'b1;
		end else if (func == OpAbs) begin
			r = lhs[DataW-1] ? -lhs : lhs; ok = 1'b1;
		end else if (szok) begin
			ok = 1'b1;
			case (func)
				OpAdd: r = a + b;
				OpSub: r = a - b;
				OpMul: r = '0;
				OpDiv, OpMod: ok = (b != '0);
				OpAnd: r = a & b;
				OpOr:  r = a | b;
				OpXor: r = a ^ b;
				OpShl: r = big ? '0 : (a << b[QbitW-1:0]);
				OpShr: r = big ? '0 : (a >> b[QbitW-1:0]);
				OpSar: r = big ? {DataW{a[DataW-1]}} : DataW'($signed(s_a) >>> b[QbitW-1:0]);
				OpRor: r = a;
				OpEq:  r = DataW'(a == b);
				OpNe:  r = DataW'(a != b);
				OpLt:  r = DataW'($signed(ka) <  $signed(kb));
				OpLe:  r = DataW'($signed(ka) <= $signed(kb));
				OpGt:  r = DataW'($signed(ka) >  $signed(kb));
				OpGe:  r = DataW'($signed(ka) >= $signed(kb));
				default: ok = 1'b0;
			endcase
		end
	end

	// capture the item at the head of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (en) begin
			item_s1.vld  <= in_vld;
			item_s1.func <= func;
			item_s1.size <= size_bytes;
			item_s1.ok   <= ok;
			item_s1.mask <= m;
			item_s1.res  <= r;
			item_s1.dvd  <= dvd_in;
			item_s1.dvs  <= dvs_in;
			item_s1.rem  <= '0;
		end
	end

endmodule

// ----- rtl/core/scfa_cell.sv -----
// ----------------------------------------------------------------------------
// scfa_cell: one restoring-division or shift-and-add multiply step
// Shifts one dividend bit into the remainder, or one multiplier bit into the product.
// ----------------------------------------------------------------------------
module scfa_cell import scfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  scfa_item_t din,
	output scfa_item_t dout_q
);

	logic [DataW:0]   trial;
	logic [DataW:0]   sub;
	scfa_item_t       nxt;

	// multiply: double the product and add the multiplicand on a set bit;
	// otherwise try subtracting the divisor from the shifted remainder
	always_comb begin
		nxt   = din;
		trial = {din.rem, din.dvd[DataW-1]};
		sub   = trial - {1'b0, din.dvs};
		if (din.func == OpMul) begin
			nxt.rem = {din.rem[DataW-2:0], 1'b0} + (din.dvd[DataW-1] ? din.dvs : '0);
			nxt.dvd = {din.dvd[DataW-2:0], 1'b0};
		end else if (!sub[DataW]) begin
			nxt.rem = sub[DataW-1:0];
			nxt.dvd = {din.dvd[DataW-2:0], 1'b1};
		end else begin
			nxt.rem = trial[DataW-1:0];
			nxt.dvd = {din.dvd[DataW-2:0], 1'b0};
		end
	end

	// advance the item one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_q <= '0;
		end else if (en) begin
			dout_q <= nxt;
		end
	end

endmodule

// ----- rtl/core/sized_constant_fold_alu.sv -----
// ----------------------------------------------------------------------------
// sized_constant_fold_alu: sized integer constant folding
// Folds one opcode over 1..8 byte operands; mul/div/mod/rotate use a cell row.
// ----------------------------------------------------------------------------
// Each accepted input beat passes the front stage at the accepting edge, 64 cells
// and one output stage, the same path for every opcode.
// Throughput: one beat per cycle while the output is not stalled; each cell retires one quotient or product bit.
// Stalls freeze the whole row while the output beat is held.
// Reset (arst_n low) empties the row and drops any pending output beat.
module sized_constant_fold_alu import scfa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // func[4:0], size_bytes[8:5], lhs[72:9], rhs[136:73], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // value[63:0], folded[64], zero pad
);

	scfa_item_t       row [0:DataW];
	logic             en;
	logic [DataW-1:0] fin;
	scfa_item_t       last;
	logic [QbitW-1:0] rot;
	logic [QbitW:0]   rot_w;
	logic [DataW-1:0] rot_m;

	// stall the row only when the output holds an untaken beat
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	scfa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (s_tvalid),
		.func       (s_tdata[4:0]),
		.size_bytes (s_tdata[8:5]),
		.lhs        (s_tdata[72:9]),
		.rhs        (s_tdata[136:73]),
		.item_s1    (row[0])
	);

	for (genvar g = 0; g < DataW; g++) begin : g_cell
		scfa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (row[g]),
			.dout_q (row[g+1])
		);
	end

	assign last = row[DataW];

	// rotate the masked lhs by rhs modulo the width
	assign rot   = last.rem[QbitW-1:0];
	assign rot_w = {last.size, 3'b000} - {1'b0, rot};
	assign rot_m = (last.res >> rot) | (last.res << rot_w);

	// pick quotient, remainder, product, rotation or early result, then mask it, or zero it if not folded
	always_comb begin
		case (last.func)
			OpDiv:        fin = last.dvd;
			OpMod, OpMul: fin = last.rem;
			OpRor:        fin = (rot == '0) ? last.res : rot_m;
			default:      fin = last.res;
		endcase
		if (!last.ok) fin = '0;
		else fin = fin & last.mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else if (en) begin
			m_tvalid <= last.vld;
			m_tdata  <= {7'd0, last.ok, fin};
		end
	end

`ifndef NO_ASSERTIONS
	a_folded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[64] |-> m_tdata[63:0] == '0) else $error("unfolded beat nonzero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output changed in stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("row stalled with empty output");
`endif

endmodule
